### hw/rtl/min_heap_replace_top_core_assert.svh
// assertion macros shared by the min-heap replace-top core
`ifndef MIN_HEAP_REPLACE_TOP_CORE_ASSERT_SVH
`define MIN_HEAP_REPLACE_TOP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MHR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mhr assertion failed");
// next-cycle implication
`define MHR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mhr assertion failed");
`else
`define MHR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MHR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/mhr_pkg.sv
// shared types and constants of the min-heap replace-top core
`default_nettype none
package mhr_pkg;

   localparam int DATA_W = 32;
   localparam int SLOT_W = 4;
   localparam int SIZE_W = 5;

   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic [SIZE_W-1:0]        size_type;

   // action codes
   localparam logic ACTION_LOAD    = 1'b0;
   localparam logic ACTION_REPLACE = 1'b1;

   // register index decode (paddr bit 2 selects the word)
   localparam logic CSR_IDX_HEAP_SIZE = 1'b0;
   localparam size_type HEAP_SIZE_RESET = 5'd16;

   // controller to datapath commands
   typedef struct packed {
      logic accept_load;
      logic accept_replace;
      logic read_children;
      logic compare;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rsp_free;
      logic sift_done;
   } sts_type;

endpackage
`default_nettype wire

### hw/rtl/mhr_if.sv
// valid/ready channel interfaces for request and response transactions
`default_nettype none
interface mhr_req_if;
   logic                valid;
   logic                ready;
   logic                action;
   mhr_pkg::slot_type   slot;
   mhr_pkg::value_type  new_value;

   modport source (output valid, output action, output slot, output new_value, input ready);
   modport sink   (input valid, input action, input slot, input new_value, output ready);
endinterface

interface mhr_rsp_if;
   logic                valid;
   logic                ready;
   mhr_pkg::value_type  top_value;

   modport source (output valid, output top_value, input ready);
   modport sink   (input valid, input top_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/mhr_ctrl.sv
// sequencer for load and sift-down transactions
`default_nettype none
`include "min_heap_replace_top_core_assert.svh"
module mhr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   output logic                  req_ready,
   input  wire mhr_pkg::sts_type sts,
   output mhr_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       take;

   // accept only when idle and the response register can take a result
   assign req_ready = (state_ff == S_IDLE) && sts.rsp_free;
   assign take      = req_valid && req_ready;

   // command decode
   always_comb begin
      cmd                = '0;
      cmd.accept_load    = take && (req_action == mhr_pkg::ACTION_LOAD);
      cmd.accept_replace = take && (req_action == mhr_pkg::ACTION_REPLACE);
      cmd.read_children  = (state_ff == S_READ);
      cmd.compare        = (state_ff == S_CMP);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept_replace) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = sts.sift_done ? S_IDLE : S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MHR_ASSERT_NXT(a_read_then_cmp, clock, reset, state_ff == S_READ, state_ff == S_CMP)
   `MHR_ASSERT_NXT(a_done_to_idle, clock, reset, cmd.compare && sts.sift_done,
                   state_ff == S_IDLE)

endmodule
`default_nettype wire

### hw/rtl/mhr_datapath.sv
// heap memory, sift-down compare unit, root shadow and response register
`default_nettype none
`include "min_heap_replace_top_core_assert.svh"
module mhr_datapath #(
   parameter int HEAP_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mhr_pkg::cmd_type   cmd,
   output mhr_pkg::sts_type        sts,
   input  wire mhr_pkg::slot_type  req_slot,
   input  wire mhr_pkg::value_type req_new_value,
   input  wire mhr_pkg::size_type  heap_size,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mhr_pkg::value_type      rsp_top_value
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   // child indexes reach 2*depth, heap_size is five bits
   localparam int CW = ((AW + 2) > (mhr_pkg::SIZE_W + 1)) ? (AW + 2) : (mhr_pkg::SIZE_W + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

   mhr_pkg::value_type mem [HEAP_DEPTH];

   logic [AW-1:0]      pos_ff;
   logic [AW-1:0]      pos_in;
   mhr_pkg::value_type v_ff;
   mhr_pkg::value_type v_in;
   mhr_pkg::value_type top_ff;
   mhr_pkg::value_type top_in;
   mhr_pkg::value_type rd_l_ff;
   mhr_pkg::value_type rd_r_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   mhr_pkg::value_type rsp_data_ff;
   mhr_pkg::value_type rsp_data_in;

   logic [CW-1:0]      size_ext;
   logic [CW-1:0]      n_live;
   logic [CW-1:0]      left_idx;
   logic [CW-1:0]      right_idx;
   logic [CW-1:0]      slot_ext;
   logic               slot_ok;
   logic               take_l;
   logic               take_r;
   logic               stop;
   mhr_pkg::value_type best_a;
   mhr_pkg::value_type best_val;
   logic [CW-1:0]      best_idx;
   logic               we;
   logic [AW-1:0]      waddr;
   mhr_pkg::value_type wdata;

   // live heap length saturates at the memory depth
   assign size_ext  = CW'(heap_size);
   assign n_live    = (size_ext > DEPTH_C) ? DEPTH_C : size_ext;
   assign left_idx  = (CW'(pos_ff) << 1) + CW'(1);
   assign right_idx = left_idx + CW'(1);
   assign slot_ext  = CW'(req_slot);
   assign slot_ok   = slot_ext < DEPTH_C;

   // pick the smaller child, left wins ties
   assign take_l   = (left_idx < n_live) && (v_ff > rd_l_ff);
   assign best_a   = take_l ? rd_l_ff : v_ff;
   assign take_r   = (right_idx < n_live) && (best_a > rd_r_ff);
   assign stop     = !take_l && !take_r;
   assign best_val = take_r ? rd_r_ff : rd_l_ff;
   assign best_idx = take_r ? right_idx : left_idx;

   // single write port: load slot, moved-up child, or final resting value
   always_comb begin
      we    = 1'b0;
      waddr = pos_ff;
      wdata = v_ff;
      if (cmd.accept_load) begin
         we    = slot_ok;
         waddr = slot_ext[AW-1:0];
         wdata = req_new_value;
      end else if (cmd.compare) begin
         we    = 1'b1;
         waddr = pos_ff;
         wdata = stop ? v_ff : best_val;
      end
   end

   // sift position, carried value and root shadow
   always_comb begin
      pos_in = pos_ff;
      v_in   = v_ff;
      top_in = top_ff;
      if (cmd.accept_replace) begin
         pos_in = '0;
         v_in   = req_new_value;
      end else if (cmd.compare && !stop) begin
         pos_in = best_idx[AW-1:0];
      end
      if (we && (waddr == '0)) begin
         top_in = wdata;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.accept_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (slot_ok && (slot_ext == '0)) ? req_new_value : top_ff;
      end else if (cmd.compare && stop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (pos_ff == '0) ? v_ff : top_ff;
      end
   end

   // heap memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.read_children) begin
         rd_l_ff <= mem[left_idx[AW-1:0]];
         rd_r_ff <= mem[right_idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      v_ff        <= v_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign sts.sift_done  = stop;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_value  = rsp_data_ff;

   `MHR_ASSERT_NXT(a_pos_descends, clock, reset, cmd.compare && !stop,
                   pos_ff > $past(pos_ff))
   `MHR_ASSERT_NXT(a_sift_rsp_empty, clock, reset, cmd.accept_replace, !rsp_valid_ff)
   `MHR_ASSERT_NXT(a_sift_end_rsp, clock, reset, cmd.compare && stop, rsp_valid_ff)

endmodule
`default_nettype wire

### hw/rtl/min_heap_replace_top_core.sv
// top level: register port, controller and datapath of the min-heap replace-top core
// load transaction: result registered at the accept edge, valid on the next cycle
// replace transaction: accept, then L levels compared (up to log2(size)+1, 5 at 16)
// each level runs a child read state and then a compare/write state on the one write port
// accepts one transaction at a time, only while the response register is free
// synchronous reset clears control state and sets heap_size to 16; heap entries stay unknown
`default_nettype none
module min_heap_replace_top_core #(
   parameter int HEAP_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mhr_req_if.sink          req,
   mhr_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   mhr_pkg::size_type heap_size_ff;
   mhr_pkg::size_type heap_size_in;
   mhr_pkg::cmd_type  cmd;
   mhr_pkg::sts_type  sts;
   logic              csr_wr;

   // register write and read back
   assign pready       = 1'b1;
   assign csr_wr       = psel && penable && pwrite && pready &&
                         (paddr[2] == mhr_pkg::CSR_IDX_HEAP_SIZE);
   assign heap_size_in = csr_wr ? pwdata[mhr_pkg::SIZE_W-1:0] : heap_size_ff;
   assign prdata       = (paddr[2] == mhr_pkg::CSR_IDX_HEAP_SIZE) ?
                         32'(heap_size_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_size_ff <= mhr_pkg::HEAP_SIZE_RESET;
      end else begin
         heap_size_ff <= heap_size_in;
      end
   end

   // controller
   mhr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   mhr_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_slot      (req.slot),
      .req_new_value (req.new_value),
      .heap_size     (heap_size_ff),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_top_value (rsp.top_value)
   );

endmodule
`default_nettype wire
